FILE: hw/rtl/itl_pkg.sv
// Shared constants, codes and control structs for the interpolating table lookup.
package itl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 9;

    // Word field widths
    localparam int VAL_W  = 16;
    localparam int POS_W  = 32;
    localparam int FRAC_W = 16;

    // Scaled position: fraction of one period times a length
    localparam int PROD_W = FRAC_W + LEN_W;

    // Value returned for a table of one entry or fewer (1.0 in Q8.8)
    localparam logic signed [VAL_W-1:0] ONE_Q8_8 = 16'sh0100;

    // Item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_MODE    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic take;    // input word accepted this cycle
        logic scale;   // form scaled position and clamp flags
        logic rd_lo;   // resolve indexes, read lower entry
        logic rd_hi;   // latch lower entry, read upper entry
        logic interp;  // multiply difference by fraction
        logic finish;  // load output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_lookup;  // word on the input channel is a lookup
    } t_dp_stat;

endpackage

FILE: hw/rtl/itl_item_if.sv
// Input channel: load and lookup words.
interface itl_item_if;
    import itl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [7:0]              entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [POS_W-1:0] position;

    modport source (output valid, command, entry_index, entry_value, position, input ready);
    modport sink   (input valid, command, entry_index, entry_value, position, output ready);
endinterface

FILE: hw/rtl/itl_result_if.sv
// Output channel: looked up values.
interface itl_result_if;
    import itl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] looked_up_value;

    modport source (output valid, looked_up_value, input ready);
    modport sink   (input valid, looked_up_value, output ready);
endinterface

FILE: hw/rtl/itl_cfg_if.sv
// Configuration write channel.
interface itl_cfg_if;
    import itl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/interpolating_table_lookup_top.sv
// Interpolating table lookup: top level joining controller and datapath.
//
// Channels: i_item carries load and lookup words, o_result carries looked up
// values, i_cfg writes table_length (0), clamp_mode (1) and snap_mode (2).
// Config writes are always taken and must only be issued while no lookup
// is in flight.
// A load word writes one table entry in the cycle it is accepted and gives
// no output word; loads can be accepted every cycle while no lookup is
// in flight. A lookup word is accepted, then passes through scale, read
// lower entry, read upper entry, multiply and sum; its output word is valid
// once the sum step has loaded the output register. No new word is taken
// until the lookup has left its sum step. The single read port of the table
// memory and the two dependent multiplies set this sequence of steps.
// The result sits in an output register; a new word can be accepted while
// it waits, but a following lookup holds in its sum step until the receiver
// takes the previous result.
// Reset: table_length 1, clamp and snap off, no word pending. Table entries
// are not cleared and hold nothing defined until loaded.
module interpolating_table_lookup_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itl_cfg_if.sink      i_cfg,
    itl_item_if.sink     i_item,
    itl_result_if.source o_result
);
    import itl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign i_cfg.ready = 1'b1;

    itl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    itl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_command         (i_item.command),
        .i_entry_index     (i_item.entry_index),
        .i_entry_value     (i_item.entry_value),
        .i_position        (i_item.position),
        .o_looked_up_value (o_result.looked_up_value)
    );

endmodule

FILE: hw/rtl/itl_dp.sv
// Datapath: config registers, table memory, scaling and interpolation arithmetic.
module itl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  itl_pkg::t_dp_cmd                i_cmd,
    output itl_pkg::t_dp_stat               o_stat,
    input  logic                            i_cfg_we,
    input  logic [itl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [itl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_command,
    input  logic [7:0]                      i_entry_index,
    input  logic signed [itl_pkg::VAL_W-1:0] i_entry_value,
    input  logic signed [itl_pkg::POS_W-1:0] i_position,
    output logic signed [itl_pkg::VAL_W-1:0] o_looked_up_value
);
    import itl_pkg::*;

    // Config registers
    logic [LEN_W-1:0] r_table_length;
    logic             r_clamp_mode;
    logic             r_snap_mode;

    // Table memory
    logic [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // Lookup pipeline registers
    logic signed [POS_W-1:0]  r_pos;
    logic [PROD_W-1:0]        r_prod;
    logic [LEN_W-1:0]         r_len;
    logic                     r_short;
    logic                     r_edge_hi;
    logic                     r_edge_lo;
    logic [ADDR_W-1:0]        r_hi_addr;
    logic [FRAC_W-1:0]        r_frac;
    logic signed [VAL_W-1:0]  r_v0;
    logic signed [2*VAL_W+1:0] r_iprod;
    logic signed [VAL_W-1:0]  r_out;

    // Scale stage signals
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  mult_len;
    logic              pos_le0;
    logic              pos_ge1;

    // Index stage signals
    logic [ADDR_W-1:0] ip;
    logic [ADDR_W-1:0] last_idx;
    logic [LEN_W-1:0]  ip_inc;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [FRAC_W-1:0] frac;

    // Interpolation signals
    logic signed [VAL_W:0] diff;

    assign o_stat.is_lookup = (i_command == CMD_LOOKUP);

    // Config writes; unlisted indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= LEN_W'(1);
            r_clamp_mode   <= 1'b0;
            r_snap_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TABLE_LENGTH: r_table_length <= i_cfg_data;
                CFG_CLAMP_MODE:   r_clamp_mode   <= i_cfg_data[0];
                CFG_SNAP_MODE:    r_snap_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Length in use, capped at the table depth
    assign len_eff  = (r_table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                             : r_table_length;
    assign mult_len = r_clamp_mode ? (len_eff - LEN_W'(1)) : len_eff;
    assign pos_le0  = r_pos[POS_W-1] || (r_pos == '0);
    assign pos_ge1  = !r_pos[POS_W-1] && (r_pos[POS_W-2:FRAC_W] != '0);

    // Only the fraction of a period matters: whole periods drop out of the wrap,
    // and clamp handles anything outside (0, 1.0) at the ends.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pos <= i_position;
        end
        if (i_cmd.scale) begin
            r_prod    <= PROD_W'(r_pos[FRAC_W-1:0]) * PROD_W'(mult_len);
            r_len     <= len_eff;
            r_short   <= (len_eff <= LEN_W'(1));
            r_edge_hi <= r_clamp_mode && pos_ge1;
            r_edge_lo <= r_clamp_mode && pos_le0;
        end
    end

    // Resolve lower/upper indexes and fraction
    assign ip       = r_prod[FRAC_W +: ADDR_W];
    assign last_idx = ADDR_W'(r_len - LEN_W'(1));
    assign ip_inc   = LEN_W'(ip) + LEN_W'(1);

    always_comb begin
        lo_addr = ip;
        hi_addr = ADDR_W'(ip_inc);
        frac    = r_prod[FRAC_W-1:0];
        if (r_edge_hi) begin
            lo_addr = last_idx;
            hi_addr = last_idx;
            frac    = '0;
        end else if (r_edge_lo) begin
            lo_addr = '0;
            hi_addr = '0;
            frac    = '0;
        end else if (!r_clamp_mode && (ip_inc >= r_len)) begin
            // entry after the last wraps to entry 0
            hi_addr = '0;
        end
        if (r_snap_mode) begin
            frac = '0;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_command == CMD_LOAD)
            && ({1'b0, i_entry_index} < 9'(TABLE_DEPTH))) begin
            r_mem[i_entry_index[ADDR_W-1:0]] <= i_entry_value;
        end
        if (i_cmd.rd_lo) begin
            r_rd_data <= r_mem[lo_addr];
        end else if (i_cmd.rd_hi) begin
            r_rd_data <= r_mem[r_hi_addr];
        end
    end

    // Interpolation: v0 + floor((v1 - v0) * f / 2^16)
    assign diff = (VAL_W+1)'($signed(r_rd_data)) - (VAL_W+1)'(r_v0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_lo) begin
            r_hi_addr <= hi_addr;
            r_frac    <= frac;
        end
        if (i_cmd.rd_hi) begin
            r_v0 <= $signed(r_rd_data);
        end
        if (i_cmd.interp) begin
            r_iprod <= (2*VAL_W+2)'(diff) * (2*VAL_W+2)'($signed({1'b0, r_frac}));
        end
        if (i_cmd.finish) begin
            r_out <= r_short ? ONE_Q8_8 : (r_v0 + r_iprod[FRAC_W +: VAL_W]);
        end
    end

    assign o_looked_up_value = r_out;

endmodule

FILE: hw/rtl/itl_ctrl.sv
// Controller: sequences one lookup through scale, two reads, multiply and sum.
module itl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  itl_pkg::t_dp_stat i_stat,
    output itl_pkg::t_dp_cmd  o_cmd
);
    import itl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCALE = 6'b000010,
        S_RDLO  = 6'b000100,
        S_RDHI  = 6'b001000,
        S_MUL   = 6'b010000,
        S_SUM   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   take;
    logic   finish;

    // Words are taken only between lookups; loads finish in the accept cycle
    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready;
    assign finish     = (r_state == S_SUM) && (!r_out_valid || i_out_ready);

    assign o_cmd.take   = take;
    assign o_cmd.scale  = (r_state == S_SCALE);
    assign o_cmd.rd_lo  = (r_state == S_RDLO);
    assign o_cmd.rd_hi  = (r_state == S_RDHI);
    assign o_cmd.interp = (r_state == S_MUL);
    assign o_cmd.finish = finish;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (take && i_stat.is_lookup) n_state = S_SCALE;
            S_SCALE: n_state = S_RDLO;
            S_RDLO:  n_state = S_RDHI;
            S_RDHI:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // An accepted lookup starts the sequence
    a_lookup_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_stat.is_lookup) |=> (r_state == S_SCALE))
        else $error("accepted lookup did not start scaling");

    // A result waiting on a stalled receiver holds the sequencer in the sum step
    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_out_valid && !i_out_ready) |=> (r_state == S_SUM))
        else $error("sum step left while output register was full");

    // Every finished lookup presents a word
    a_finish_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished lookup produced no output word");

    // Upper read always follows the lower read
    a_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDHI) |-> ($past(r_state) == S_RDLO))
        else $error("upper entry read out of order");
`endif

endmodule

FILE: test/itl_checker.sv
// Scoreboard for the interpolating table lookup: mirrors table and modes, checks result words.
module itl_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    itl_cfg_if     cfg_bus,
    itl_item_if    item_bus,
    itl_result_if  result_bus,
    output int     o_pending,
    output int     o_fail_count
);
    import itl_pkg::*;

    // Shadow copy of the table and of the mode registers
    logic signed [VAL_W-1:0] entry_copy [TABLE_DEPTH];
    logic [LEN_W-1:0]        cur_length;
    logic                    cur_clamp;
    logic                    cur_snap;

    logic signed [VAL_W-1:0] expected_values [$];
    int                      fail_total = 0;

    // Value a lookup at this position must return under the current modes
    function automatic logic signed [VAL_W-1:0] interp_value(logic signed [POS_W-1:0] pos);
        longint len, scaled, ip, frac, v0, v1, acc, lo_idx, hi_idx;
        len = longint'(cur_length);
        if (len > TABLE_DEPTH) len = TABLE_DEPTH;
        if (len <= 1) return ONE_Q8_8;
        if (cur_clamp) begin
            scaled = longint'(pos) * (len - 1);
            if (scaled >= (len - 1) * 65536) return entry_copy[len - 1];
            if (scaled <= 0) return entry_copy[0];
            lo_idx = scaled >>> FRAC_W;
            hi_idx = lo_idx + 1;
        end else begin
            scaled = longint'(pos) * len;
            // floor of the scaled position, folded into one period
            ip = (scaled >>> FRAC_W) % len;
            if (ip < 0) ip += len;
            lo_idx = ip;
            hi_idx = (ip + 1 >= len) ? 0 : ip + 1;
        end
        frac = scaled & 64'hFFFF;
        v0 = entry_copy[lo_idx];
        if (cur_snap) return v0[VAL_W-1:0];
        v1 = entry_copy[hi_idx];
        acc = v0 * (65536 - frac) + v1 * frac;
        // arithmetic shift floors toward minus infinity
        return acc[VAL_W+FRAC_W-1:FRAC_W];
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin : track
        logic signed [VAL_W-1:0] want;
        if (!i_rst_n) begin
            cur_length = 9'd1;
            cur_clamp  = 1'b0;
            cur_snap   = 1'b0;
            expected_values.delete();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_TABLE_LENGTH: cur_length = cfg_bus.data;
                    CFG_CLAMP_MODE:   cur_clamp  = cfg_bus.data[0];
                    CFG_SNAP_MODE:    cur_snap   = cfg_bus.data[0];
                    default: ;
                endcase
            end
            // result words are matched before this edge's lookup is queued
            if (result_bus.valid && result_bus.ready) begin
                if (expected_values.size() == 0) begin
                    $error("looked_up_value: expected no word, actual %0d",
                           result_bus.looked_up_value);
                    fail_total++;
                end else begin
                    want = expected_values.pop_front();
                    if (result_bus.looked_up_value !== want) begin
                        $error("looked_up_value: expected %0d, actual %0d",
                               want, result_bus.looked_up_value);
                        fail_total++;
                    end
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                if (item_bus.command == CMD_LOOKUP)
                    expected_values.push_back(interp_value(item_bus.position));
                else
                    entry_copy[item_bus.entry_index] = item_bus.entry_value;
            end
        end
        o_pending    <= expected_values.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the interpolating table lookup: clock, reset, stimulus and verdict.
module tb_top;
    import itl_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itl_cfg_if    cfg_bus();
    itl_item_if   item_bus();
    itl_result_if result_bus();

    int pending;
    int fail_count;
    int hold_requests = 0;
    bit tx_steady = 1'b0;
    int table_len = 1;
    bit loaded [TABLE_DEPTH];

    interpolating_table_lookup_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    itl_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_bus      (cfg_bus),
        .item_bus     (item_bus),
        .result_bus   (result_bus),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Lookup positions: mostly within two periods either side, some near
    // the table ends, some anywhere in the 32-bit range
    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 32'h0001_0000 + $urandom_range(0, 64) - 32;
            3:       return $urandom_range(0, 64) - 32;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Result side: random stalls, steady stretches, long hold on request
    initial begin : receiver
        int  stall_left;
        int  holds_served;
        bit  steady;
        stall_left   = 0;
        holds_served = 0;
        steady       = 1'b0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = LONG_HOLD - 1;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
                if ($urandom_range(0, 99) == 0) steady = !steady;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    // One word on the item channel; valid stays high on return
    task automatic send_word(logic cmd, logic [7:0] idx, logic [VAL_W-1:0] val,
                             logic [POS_W-1:0] pos);
        if (!tx_steady && $urandom_range(0, 2) == 0) begin
            item_bus.valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.command     <= cmd;
        item_bus.entry_index <= idx;
        item_bus.entry_value <= val;
        item_bus.position    <= pos;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    task automatic send_load(logic [7:0] idx, logic [VAL_W-1:0] val);
        loaded[idx] = 1'b1;
        send_word(CMD_LOAD, idx, val, $urandom);
    endtask

    task automatic send_lookup(logic [POS_W-1:0] pos);
        send_word(CMD_LOOKUP, 8'($urandom), VAL_W'($urandom), pos);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    // Only called with the block idle; mode words carry junk in the upper bits
    task automatic set_mode(int len, bit clamp, bit snap);
        write_reg(CFG_TABLE_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_CLAMP_MODE, {(CFG_DATA_W-1)'($urandom), clamp});
        write_reg(CFG_SNAP_MODE, {(CFG_DATA_W-1)'($urandom), snap});
        cfg_bus.valid <= 1'b0;
        table_len = len;
    endtask

    // Drop valid, let every result drain, then give loads time to land
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Load every entry in use that was never written, so no lookup reads one
    task automatic fill_table();
        int eff;
        eff = (table_len > TABLE_DEPTH) ? TABLE_DEPTH : table_len;
        for (int i = 0; i < eff; i++)
            if (!loaded[i]) send_load(i[7:0], VAL_W'($urandom));
    endtask

    // One setting: reconfigure, fill, then a random mix of loads and lookups
    task automatic run_phase(int len, bit clamp, bit snap, int count, bit squeeze);
        wait_idle();
        set_mode(len, clamp, snap);
        tx_steady = ($urandom_range(0, 3) == 0);
        fill_table();
        if (squeeze) begin
            // keep offering lookups while the receiver is held off
            tx_steady = 1'b1;
            hold_requests <= hold_requests + 1;
        end
        for (int n = 0; n < count; n++) begin
            if (!squeeze && $urandom_range(0, 3) == 0)
                send_load(8'($urandom), VAL_W'($urandom));
            else
                send_lookup(pick_position());
        end
    endtask

    initial begin : timeout
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        i_rst_n          <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_TABLE_LENGTH;
        cfg_bus.data     <= '0;
        item_bus.valid   <= 1'b0;
        item_bus.command <= CMD_LOAD;
        item_bus.entry_index <= '0;
        item_bus.entry_value <= '0;
        item_bus.position    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short table: reset length of one, then length zero
        send_lookup(32'h0000_0000);
        send_lookup(32'h7FFF_FFFF);
        wait_idle();
        set_mode(0, 1'b0, 1'b0);
        send_lookup(32'h8000_0000);

        // extreme entry values and the top slot
        send_load(8'd0, 16'h7FFF);
        send_load(8'd1, 16'h8000);
        send_load(8'd2, 16'h0100);
        send_load(8'd3, 16'hFFFF);
        send_load(8'd255, 16'h5A5A);

        // wrap: interpolation across extremes, last-to-first, negative wrap
        wait_idle();
        set_mode(4, 1'b0, 1'b0);
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_2000);
        send_lookup(32'h0000_E000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h8000_0000);
        send_lookup(32'h7FFF_FFFF);

        // clamp: top, bottom, below zero, interior
        wait_idle();
        set_mode(4, 1'b1, 1'b0);
        send_lookup(32'h0001_0000);
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_0000);
        send_lookup(32'h0000_2AAB);
        send_lookup(32'h0000_FFFF);

        // snap to the lower entry
        wait_idle();
        set_mode(4, 1'b0, 1'b1);
        send_lookup(32'h0000_2000);
        send_lookup(32'hFFFF_F000);

        // random part over a spread of settings, lengths past the depth too
        run_phase(2, 1'b0, 1'b0, 30, 1'b0);
        run_phase(2, 1'b1, 1'b1, 25, 1'b0);
        run_phase(3, 1'b1, 1'b0, 30, 1'b0);
        run_phase(256, 1'b0, 1'b0, 40, 1'b0);
        run_phase(256, 1'b1, 1'b0, 40, 1'b1);
        run_phase(511, 1'b0, 1'b1, 25, 1'b0);
        run_phase(300, 1'b1, 1'b1, 25, 1'b0);
        run_phase(1, 1'b0, 1'b0, 10, 1'b0);
        run_phase(0, 1'b1, 1'b0, 10, 1'b0);
        run_phase(255, 1'b0, 1'b0, 30, 1'b0);
        for (int p = 0; p < 8; p++)
            run_phase(int'($urandom_range(2, 256)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 20, 1'b0);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/itl_pkg.sv
hw/rtl/itl_item_if.sv
hw/rtl/itl_result_if.sv
hw/rtl/itl_cfg_if.sv
hw/rtl/itl_dp.sv
hw/rtl/itl_ctrl.sv
hw/rtl/interpolating_table_lookup_top.sv
test/itl_checker.sv
test/tb_top.sv
